FILE: hw/rtl/dcbq_pkg.sv
// ----------------------------------------------------------------------------
// dcbq_pkg
// Shared types, widths and coefficient tables for the DC-blocking biquad
// cascade.
// ----------------------------------------------------------------------------
package dcbq_pkg;

    // History word and fraction positions
    localparam int HIST_W   = 32;
    localparam int COEF_FRAC = 30;
    // x * 2^30 plus four 64-bit products never needs more than 67 bits
    localparam int ACC_W    = 67;
    localparam int PROD_W   = 64;
    localparam int TERMS    = 4;
    localparam int COEF_SETS = 3;

    // Output gain, Q2.30
    localparam logic signed [HIST_W-1:0] GAIN_Q30 = 32'sd1070792545;

    // Forward half of the link between two cells
    typedef struct packed {
        logic                     valid;
        logic signed [HIST_W-1:0] value;
        logic                     clip;
    } dcbq_link_t;

    // Multiplier coefficient for one term of one section, Q2.30.
    // Term order follows the history slots: x1, x2, y1, y2. The feedback
    // terms are stored negated so every term simply accumulates.
    // Sections past the last coefficient set pass their input through.
    function automatic logic signed [HIST_W-1:0] coef_term(input int set_idx,
                                                           input logic [1:0] term);
        logic signed [HIST_W-1:0] c;
        c = '0;
        unique case (set_idx)
            0: begin
                unique case (term)
                    2'd0: c = -32'sd2147483111;
                    2'd1: c =  32'sd1073741824;
                    2'd2: c =  32'sd2147205227;
                    2'd3: c = -32'sd1073465368;
                endcase
            end
            1: begin
                unique case (term)
                    2'd0: c = -32'sd2147483326;
                    2'd1: c =  32'sd1073741824;
                    2'd2: c =  32'sd2146233061;
                    2'd3: c = -32'sd1072494093;
                endcase
            end
            2: begin
                unique case (term)
                    2'd0: c = 32'h8000_0000;
                    2'd1: c =  32'sd1073741824;
                    2'd2: c =  32'sd2143104714;
                    2'd3: c = -32'sd1069369257;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/dcbq_in_if.sv
// ----------------------------------------------------------------------------
// dcbq_in_if
// Sample input channel: valid/ready handshake carrying one audio sample.
// ----------------------------------------------------------------------------
interface dcbq_in_if #(
    parameter int W = 24
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: hw/rtl/dcbq_out_if.sv
// ----------------------------------------------------------------------------
// dcbq_out_if
// Result channel: valid/ready handshake carrying a filtered sample and the
// clip flag.
// ----------------------------------------------------------------------------
interface dcbq_out_if #(
    parameter int W = 24
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_out;
    logic                clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: hw/rtl/dcbq_cell.sv
// ----------------------------------------------------------------------------
// dcbq_cell
// One direct-form-I biquad section. Holds its own x1/x2/y1/y2 history and
// works through the four products on a local multiplier, then hands the
// rounded, saturated result to the next cell.
// ----------------------------------------------------------------------------
module dcbq_cell
    import dcbq_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dcbq_link_t up,
    output logic       up_ready,
    output dcbq_link_t down,
    input  logic       down_ready
);

    localparam logic [2:0] LAST_STEP = 3'd5;

    logic                     busy_reg;
    logic [2:0]               step_reg;
    logic signed [HIST_W-1:0] x_reg;
    logic                     clip_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [HIST_W-1:0] hist_reg [TERMS];
    logic                     out_valid_reg;
    logic signed [HIST_W-1:0] out_value_reg;
    logic                     out_clip_reg;

    logic signed [HIST_W-1:0] y_next;
    logic                     y_clip;
    logic                     finish;
    logic                     slot_free;
    logic signed [HIST_W-1:0] mul_coef;
    logic signed [HIST_W-1:0] mul_hist;

    assign up_ready  = !busy_reg;
    assign slot_free = !out_valid_reg || down_ready;
    assign finish    = busy_reg && (step_reg == LAST_STEP) && slot_free;

    // multiplier operands by step: x1, x2, y1, y2
    assign mul_coef = coef_term(CELL_INDEX, step_reg[1:0]);
    assign mul_hist = hist_reg[step_reg[1:0]];

    // round already folded into acc; drop fraction and saturate to 32 bits
    always_comb
    begin
        y_next = acc_reg[COEF_FRAC +: HIST_W];
        y_clip = 1'b0;
        if (acc_reg[ACC_W-1:COEF_FRAC+HIST_W-1] != '0 &&
            acc_reg[ACC_W-1:COEF_FRAC+HIST_W-1] != '1)
        begin
            y_clip = 1'b1;
            y_next = acc_reg[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}}
                                      : {1'b0, {(HIST_W-1){1'b1}}};
        end
    end

    // control and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TERMS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && down_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (!busy_reg)
            begin
                if (up.valid)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
            end
            else if (step_reg != LAST_STEP)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else if (finish)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                hist_reg[1]   <= hist_reg[0];
                hist_reg[0]   <= x_reg;
                hist_reg[3]   <= hist_reg[2];
                hist_reg[2]   <= y_next;
            end
        end
    end

    // datapath: load, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (!busy_reg && up.valid)
        begin
            x_reg    <= up.value;
            clip_reg <= up.clip;
            acc_reg  <= (ACC_W'(up.value) <<< COEF_FRAC)
                        + (ACC_W'(1) <<< (COEF_FRAC - 1));
        end
        if (busy_reg && step_reg < 3'(TERMS))
        begin
            prod_reg <= mul_coef * mul_hist;
        end
        if (busy_reg && step_reg >= 3'd1 && step_reg <= 3'(TERMS))
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (finish)
        begin
            out_value_reg <= y_next;
            out_clip_reg  <= clip_reg | y_clip;
        end
    end

    assign down.valid = out_valid_reg;
    assign down.value = out_value_reg;
    assign down.clip  = out_clip_reg;

endmodule

FILE: hw/rtl/dcbq_gain.sv
// ----------------------------------------------------------------------------
// dcbq_gain
// Output stage: scales the cascade result by the fixed gain, rounds,
// saturates to the sample width and holds the result for the receiver.
// ----------------------------------------------------------------------------
module dcbq_gain
    import dcbq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dcbq_link_t                    up,
    output logic                          up_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_sample,
    output logic                          out_clip
);

    logic                           busy_reg;
    logic                           have_prod_reg;
    logic signed [HIST_W-1:0]       y_reg;
    logic                           clip_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_clip_reg;

    logic signed [PROD_W-1:0]       rounded;
    logic signed [PROD_W-COEF_FRAC-1:0] scaled;
    logic signed [SAMPLE_WIDTH-1:0] sat_next;
    logic                           sat_clip;
    logic                           finish;

    assign up_ready = !busy_reg;
    assign finish   = busy_reg && have_prod_reg && (!out_valid_reg || out_ready);

    // round half up, floor shift, saturate
    always_comb
    begin
        rounded  = prod_reg + (PROD_W'(1) <<< (COEF_FRAC - 1));
        scaled   = rounded[PROD_W-1:COEF_FRAC];
        sat_next = scaled[SAMPLE_WIDTH-1:0];
        sat_clip = 1'b0;
        if (scaled[PROD_W-COEF_FRAC-1:SAMPLE_WIDTH-1] != '0 &&
            scaled[PROD_W-COEF_FRAC-1:SAMPLE_WIDTH-1] != '1)
        begin
            sat_clip = 1'b1;
            sat_next = scaled[PROD_W-COEF_FRAC-1]
                       ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                       : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            have_prod_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (!busy_reg)
            begin
                if (up.valid)
                begin
                    busy_reg      <= 1'b1;
                    have_prod_reg <= 1'b0;
                end
            end
            else if (!have_prod_reg)
            begin
                have_prod_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg      <= 1'b0;
                have_prod_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (!busy_reg && up.valid)
        begin
            y_reg    <= up.value;
            clip_reg <= up.clip;
        end
        if (busy_reg && !have_prod_reg)
        begin
            prod_reg <= y_reg * GAIN_Q30;
        end
        if (finish)
        begin
            out_sample_reg <= sat_next;
            out_clip_reg   <= clip_reg | sat_clip;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_clip   = out_clip_reg;

endmodule

FILE: hw/rtl/dc_blocking_biquad_cascade_core.sv
// ----------------------------------------------------------------------------
// dc_blocking_biquad_cascade_core
// DC-removing highpass: a chain of biquad section cells and a gain stage.
// ----------------------------------------------------------------------------
// Usage:
//   samples : valid/ready sink, one signed Q1.23 sample per transaction.
//   results : valid/ready source, filtered sample plus clip flag, one
//             transaction per input transaction, in order.
// Each section cell owns its four history words and a 32x32 multiplier; it
// works through each sample in turn: load, four products, accumulate, round
// and saturate. The gain stage multiplies by the gain, then rounds and
// saturates into its output register. Cells run concurrently on successive
// samples; a cell takes a new sample only once it has finished the last, so
// the per-cell multiply-accumulate loop sets the rate at which the chain
// accepts transactions.
// Reset clears all histories to zero and empties every cell.
// When the receiver stalls, the finished result is held in the output
// register; the next sample completes into that stage only once it frees,
// and backpressure then walks back cell by cell to samples.ready.
// ----------------------------------------------------------------------------
module dc_blocking_biquad_cascade_core
    import dcbq_pkg::*;
#(
    parameter int SECTIONS     = 3,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    dcbq_in_if.sink    samples,
    dcbq_out_if.source results
);

    dcbq_link_t link  [SECTIONS+1];
    logic       ready [SECTIONS+1];

    // head of chain: widen the sample to history width
    assign link[0].valid = samples.valid;
    assign link[0].value = HIST_W'(samples.sample_in);
    assign link[0].clip  = 1'b0;
    assign samples.ready = ready[0];

    // section cells
    for (genvar s = 0; s < SECTIONS; s++)
    begin : g_cell
        dcbq_cell #(
            .CELL_INDEX (s)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up         (link[s]),
            .up_ready   (ready[s]),
            .down       (link[s+1]),
            .down_ready (ready[s+1])
        );
    end

    // gain and output register
    dcbq_gain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .up         (link[SECTIONS]),
        .up_ready   (ready[SECTIONS]),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_sample (results.sample_out),
        .out_clip   (results.clipped)
    );

endmodule
